// ===== hw/rtl/fmlp_pkg.sv =====
`timescale 1ns / 1ps

package fmlp_pkg;

    localparam int FEAT_W       = 8;
    localparam int WEIGHT_W     = 16;
    localparam int NUM_FEATURES = 4;
    localparam int NUM_HIDDEN   = 2;
    localparam int NUM_OUT      = 2;
    localparam int HID_TAPS     = NUM_FEATURES + 1;
    localparam int OUT_TAPS     = NUM_HIDDEN + 1;
    localparam int HID_W        = 16;
    localparam int OUT_W        = 21;
    localparam int SUM_W        = 32;
    localparam int CFG_W        = 64;
    localparam int NUM_WORDS    = 4;
    localparam int INDEX_W      = 2;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 80;

    localparam logic [INDEX_W-1:0] REG_WEIGHT_WORD_0 = 2'd0;
    localparam logic [INDEX_W-1:0] REG_WEIGHT_WORD_1 = 2'd1;
    localparam logic [INDEX_W-1:0] REG_WEIGHT_WORD_2 = 2'd2;
    localparam logic [INDEX_W-1:0] REG_WEIGHT_WORD_3 = 2'd3;

    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic [FEAT_W-1:0]          feature_t;
    typedef logic signed [HID_W-1:0]    hid_act_t;
    typedef logic signed [OUT_W-1:0]    out_act_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    typedef struct packed {
        hid_act_t act_1;
        hid_act_t act_0;
    } hidden_word_t;

    // packed so that hidden_act_0 lands in the lowest bits
    typedef struct packed {
        out_act_t output_act_1;
        out_act_t output_act_0;
        hid_act_t hidden_act_1;
        hid_act_t hidden_act_0;
    } result_word_t;

    localparam int RESULT_W = $bits(result_word_t);

    // floor(sum / 256), then truncate toward zero by 1024, add one, scale by 128
    function automatic out_act_t activate(input sum_t sum);
        logic signed [SUM_W-9:0]  q;
        logic signed [SUM_W-19:0] t;
        logic signed [SUM_W-19:0] r;
        q = sum[SUM_W-1:8];
        t = q[SUM_W-9:10];
        if (q[SUM_W-9] && (q[9:0] != 10'd0))
        begin
            t = t + 14'sd1;
        end
        r = t + 14'sd1;
        activate = {r, 7'b0};
    endfunction

endpackage

// ===== hw/rtl/fmlp_hidden.sv =====
`timescale 1ns / 1ps

module fmlp_hidden
    import fmlp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  feature_t     features [NUM_FEATURES],
    input  weight_t      weights [NUM_HIDDEN*HID_TAPS],
    output logic         out_valid,
    input  logic         out_ready,
    output hidden_word_t out_word
);

    localparam int PROD_W = WEIGHT_W + FEAT_W + 1;
    localparam int HSUM_W = PROD_W + $clog2(HID_TAPS);

    logic [2:0] valid_reg;
    logic [2:0] adv;

    logic signed [PROD_W-1:0] prod_reg  [NUM_HIDDEN][HID_TAPS];
    logic signed [PROD_W-1:0] prod_next [NUM_HIDDEN][HID_TAPS];
    logic signed [HSUM_W-1:0] sum_reg   [NUM_HIDDEN];
    logic signed [HSUM_W-1:0] sum_next  [NUM_HIDDEN];
    hidden_word_t             act_reg;
    hidden_word_t             act_next;

    // a stage moves when it is empty or the one after it moves
    assign adv[2]   = !valid_reg[2] || out_ready;
    assign adv[1]   = !valid_reg[1] || adv[2];
    assign adv[0]   = !valid_reg[0] || adv[1];
    assign in_ready = adv[0];

    always_comb
    begin
        for (int j = 0; j < NUM_HIDDEN; j++)
        begin
            prod_next[j][0] = -(PROD_W'(weights[j*HID_TAPS]) <<< 8);
            for (int k = 0; k < NUM_FEATURES; k++)
            begin
                prod_next[j][k+1] = weights[j*HID_TAPS+k+1] * $signed({1'b0, features[k]});
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM_HIDDEN; j++)
        begin
            sum_next[j] = '0;
            for (int t = 0; t < HID_TAPS; t++)
            begin
                sum_next[j] = sum_next[j] + HSUM_W'(prod_reg[j][t]);
            end
        end
    end

    always_comb
    begin
        act_next.act_0 = HID_W'(activate(SUM_W'(sum_reg[0])));
        act_next.act_1 = HID_W'(activate(SUM_W'(sum_reg[1])));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (adv[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prod_reg <= prod_next;
        end
        if (adv[1])
        begin
            sum_reg <= sum_next;
        end
        if (adv[2])
        begin
            act_reg <= act_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_word  = act_reg;

`ifndef ASSERT_OFF
    // a stalled sum stage keeps its word
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] && !adv[1] |=> valid_reg[1] && $stable(sum_reg[0]) && $stable(sum_reg[1]))
        else $error("hidden sum stage changed while stalled");
`endif

endmodule

// ===== hw/rtl/fmlp_output.sv =====
`timescale 1ns / 1ps

module fmlp_output
    import fmlp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  hidden_word_t in_word,
    input  weight_t      weights [NUM_OUT*OUT_TAPS],
    output logic         out_valid,
    input  logic         out_ready,
    output result_word_t out_word
);

    logic [2:0] valid_reg;
    logic [2:0] adv;

    sum_t         prod_reg  [NUM_OUT][OUT_TAPS];
    sum_t         prod_next [NUM_OUT][OUT_TAPS];
    sum_t         sum_reg   [NUM_OUT];
    sum_t         sum_next  [NUM_OUT];
    hidden_word_t hid_reg   [2];
    result_word_t res_reg;
    result_word_t res_next;

    assign adv[2]   = !valid_reg[2] || out_ready;
    assign adv[1]   = !valid_reg[1] || adv[2];
    assign adv[0]   = !valid_reg[0] || adv[1];
    assign in_ready = adv[0];

    always_comb
    begin
        for (int j = 0; j < NUM_OUT; j++)
        begin
            prod_next[j][0] = -(SUM_W'(weights[j*OUT_TAPS]) <<< 8);
            prod_next[j][1] = weights[j*OUT_TAPS+1] * in_word.act_0;
            prod_next[j][2] = weights[j*OUT_TAPS+2] * in_word.act_1;
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM_OUT; j++)
        begin
            sum_next[j] = '0;
            for (int t = 0; t < OUT_TAPS; t++)
            begin
                sum_next[j] = sum_next[j] + prod_reg[j][t];
            end
        end
    end

    always_comb
    begin
        res_next.hidden_act_0 = hid_reg[1].act_0;
        res_next.hidden_act_1 = hid_reg[1].act_1;
        res_next.output_act_0 = activate(sum_reg[0]);
        res_next.output_act_1 = activate(sum_reg[1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (adv[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prod_reg   <= prod_next;
            hid_reg[0] <= in_word;
        end
        if (adv[1])
        begin
            sum_reg    <= sum_next;
            hid_reg[1] <= hid_reg[0];
        end
        if (adv[2])
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_word  = res_reg;

endmodule

// ===== hw/rtl/fixed_point_mlp_4_2_2_inference.sv =====
`timescale 1ns / 1ps

// 4-2-2 fixed-point perceptron, inference only.
// Slave stream: one word carries four unsigned 8-bit features; a word is taken
// at a rising edge with s_tvalid and s_tready high. Master stream: one result
// word per input word, in order, holding both hidden and both output
// activations (multiples of 128).
// Weights come in over the write port: wr_en, wr_index (0..3) and 64-bit
// wr_data, four signed 16-bit weights per register, lowest index in the low
// bits. Write them only while the pipeline is empty.
// The accepted word passes the six pipeline registers in order; m_tvalid rises
// when the output activate register holds it. The six-stage pipeline (multiply,
// sum, activate per layer) takes a new word every cycle while m_tready is high.
// Reset clears all weights to zero and empties the pipeline.
// Receiver stall: each stage holds its word while the next is full and stalled,
// and bubbles close up, so s_tready stays high until all six stages are full.
module fixed_point_mlp_4_2_2_inference
    import fmlp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // feature_0, feature_1, feature_2, feature_3 (8 bits each)
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // hidden_act_0 (16), hidden_act_1 (16), output_act_0 (21), output_act_1 (21), zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 wr_en,
    input  logic [INDEX_W-1:0]   wr_index,
    input  logic [CFG_W-1:0]     wr_data
);

    logic [CFG_W-1:0]           weight_reg [NUM_WORDS];
    logic [NUM_WORDS*CFG_W-1:0] all_weights;

    feature_t     features [NUM_FEATURES];
    weight_t      hid_weights [NUM_HIDDEN*HID_TAPS];
    weight_t      out_weights [NUM_OUT*OUT_TAPS];

    logic         hid_valid;
    logic         hid_ready;
    hidden_word_t hid_word;
    result_word_t res_word;

    // hold the weight registers; the user must write only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                weight_reg[w] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_WEIGHT_WORD_0: weight_reg[0] <= wr_data;
                REG_WEIGHT_WORD_1: weight_reg[1] <= wr_data;
                REG_WEIGHT_WORD_2: weight_reg[2] <= wr_data;
                REG_WEIGHT_WORD_3: weight_reg[3] <= wr_data;
                default: ;
            endcase
        end
    end

    // flatten the registers so that weight i sits at bits 16*i upward
    always_comb
    begin
        for (int w = 0; w < NUM_WORDS; w++)
        begin
            all_weights[w*CFG_W +: CFG_W] = weight_reg[w];
        end
        for (int i = 0; i < NUM_HIDDEN*HID_TAPS; i++)
        begin
            hid_weights[i] = all_weights[i*WEIGHT_W +: WEIGHT_W];
        end
        for (int i = 0; i < NUM_OUT*OUT_TAPS; i++)
        begin
            out_weights[i] = all_weights[(NUM_HIDDEN*HID_TAPS+i)*WEIGHT_W +: WEIGHT_W];
        end
        for (int k = 0; k < NUM_FEATURES; k++)
        begin
            features[k] = s_tdata[k*FEAT_W +: FEAT_W];
        end
    end

    fmlp_hidden u_hidden (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .features  (features),
        .weights   (hid_weights),
        .out_valid (hid_valid),
        .out_ready (hid_ready),
        .out_word  (hid_word)
    );

    fmlp_output u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hid_valid),
        .in_ready  (hid_ready),
        .in_word   (hid_word),
        .weights   (out_weights),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (res_word)
    );

    assign m_tdata = {{(M_TDATA_W-RESULT_W){1'b0}}, res_word};

`ifndef ASSERT_OFF
    // a write to weight word 2 lands in that register on the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && (wr_index == REG_WEIGHT_WORD_2) |=> weight_reg[2] == $past(wr_data))
        else $error("weight register write lost");

    // the hidden layer holds its word while the output layer is full
    assert property (@(posedge clk) disable iff (!rst_n)
        hid_valid && !hid_ready |=> hid_valid && $stable(hid_word))
        else $error("hidden word changed while stalled");

    // an empty output stage means every stage can move, so input is open
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with an empty output stage");
`endif

endmodule
